FILE: src/tcpq_pkg.sv
// ----------------------------------------------------------------------------
// tcpq_pkg
// shared types and constants for the two-class priority queue
// ----------------------------------------------------------------------------
package tcpq_pkg;

	localparam int QUEUE_DEPTH = 128;
	localparam int IDX_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int TAG_W       = 16;
	localparam int AGE_W       = 8;
	localparam int ENTRY_W     = TAG_W + AGE_W;

	localparam logic [AGE_W-1:0] AGE_THRESHOLD_RESET = 8'd65;

	// request kinds
	localparam logic KIND_ENQ = 1'b0;
	localparam logic KIND_DEQ = 1'b1;

	typedef enum logic [1:0] {
		ST_ENQUEUED = 2'd0,
		ST_REJECTED = 2'd1,
		ST_SERVED   = 2'd2,
		ST_EMPTY    = 2'd3
	} status_t;

	// commands into one queue lane
	typedef struct packed {
		logic push;
		logic pop;
	} lane_req_t;

	// lane status back to the top level
	typedef struct packed {
		logic empty;
		logic at_last;
	} lane_stat_t;

endpackage

FILE: src/tcpq_lane.sv
// ----------------------------------------------------------------------------
// tcpq_lane
// one linear array queue: entry memory plus head, tail and empty flag
// ----------------------------------------------------------------------------
module tcpq_lane (
	input  logic                         clk,
	input  logic                         arst_n,
	input  tcpq_pkg::lane_req_t          req,
	input  logic [tcpq_pkg::ENTRY_W-1:0] wr_entry,
	output tcpq_pkg::lane_stat_t         stat,
	output logic [tcpq_pkg::ENTRY_W-1:0] rd_entry
);
	import tcpq_pkg::*;

	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(QUEUE_DEPTH - 1);

	logic [ENTRY_W-1:0] mem_q [QUEUE_DEPTH];
	logic [IDX_W-1:0]   head_q;
	logic [IDX_W-1:0]   tail_q;
	logic               empty_q;
	logic [IDX_W-1:0]   wr_idx;
	logic [ENTRY_W-1:0] rd_q;

	assign stat.empty   = empty_q;
	assign stat.at_last = (tail_q == LAST_IDX);
	assign rd_entry     = rd_q;

	// first item of a drained queue lands at slot 0
	assign wr_idx = empty_q ? '0 : tail_q + IDX_W'(1);

	always_ff @(posedge clk) begin
		if (req.push) begin
			mem_q[wr_idx] <= wr_entry;
		end
		if (req.pop) begin
			rd_q <= mem_q[head_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			empty_q <= 1'b1;
		end else if (req.push) begin
			if (empty_q) begin
				head_q <= '0;
			end
			tail_q  <= wr_idx;
			empty_q <= 1'b0;
		end else if (req.pop) begin
			if (head_q == tail_q) begin
				head_q  <= '0;
				tail_q  <= '0;
				empty_q <= 1'b1;
			end else begin
				head_q <= head_q + IDX_W'(1);
			end
		end
	end

endmodule

FILE: src/two_class_priority_queue.sv
// ----------------------------------------------------------------------------
// two_class_priority_queue
// strict priority over two linear queues, steered by an age threshold
// ----------------------------------------------------------------------------
// usage
//   request channel: a word is taken at a clock edge with start high and busy
//   low. kind selects enqueue (tag, age) or dequeue. busy stays low, so a
//   request may be issued in every cycle.
//   result channel: done pulses for one cycle, the cycle right after the
//   request edge, with status, from_priority, served_tag and served_age.
//   the receiver cannot stall; every result must be taken when done is high.
//   throughput is one request per cycle, and every request gets its result:
//   each request does at most one access to one lane memory (write at the tail
//   on enqueue, read at the head on dequeue), and the read data register of
//   that memory feeds the result directly.
//   config channel: cfg_data loads the age threshold when cfg_valid is high;
//   cfg_ready is always high. write it only while no result is pending.
//   reset: both queues empty, indices at slot 0, threshold 65. entry memories
//   are not cleared; only slots that were written are ever read back.
// ----------------------------------------------------------------------------
module two_class_priority_queue (
	input  logic                       clk,
	input  logic                       arst_n,
	// request
	input  logic                       start,
	output logic                       busy,
	input  logic                       kind,
	input  logic [tcpq_pkg::TAG_W-1:0] tag,
	input  logic [tcpq_pkg::AGE_W-1:0] age,
	// result
	output logic                       done,
	output logic [1:0]                 status,
	output logic                       from_priority,
	output logic [tcpq_pkg::TAG_W-1:0] served_tag,
	output logic [tcpq_pkg::AGE_W-1:0] served_age,
	// threshold config
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [tcpq_pkg::AGE_W-1:0] cfg_data
);
	import tcpq_pkg::*;

	logic [AGE_W-1:0]   thr_q;
	logic               acc;
	logic               enq;
	logic               deq;
	logic               to_prio;
	logic               tgt_full;
	lane_req_t          p_req;
	lane_req_t          n_req;
	lane_stat_t         p_stat;
	lane_stat_t         n_stat;
	logic [ENTRY_W-1:0] p_rd;
	logic [ENTRY_W-1:0] n_rd;
	logic [ENTRY_W-1:0] wr_entry;
	logic [ENTRY_W-1:0] sel_entry;
	status_t            status_d;
	logic               prio_d;

	// result stage
	logic               valid_s1;
	status_t            status_s1;
	logic               prio_s1;

	// every request is at most one memory access, nothing to hold off
	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= AGE_THRESHOLD_RESET;
		end else if (cfg_valid && cfg_ready) begin
			thr_q <= cfg_data;
		end
	end

	// request decode
	assign acc      = start && !busy;
	assign enq      = acc && (kind == KIND_ENQ);
	assign deq      = acc && (kind == KIND_DEQ);
	assign to_prio  = age > thr_q;
	assign wr_entry = {tag, age};

	// linear queue: full once the tail reaches the last slot, even if the
	// head has moved on; an empty queue always takes the item at slot 0
	assign tgt_full = to_prio ? (!p_stat.empty && p_stat.at_last)
	                          : (!n_stat.empty && n_stat.at_last);

	always_comb begin
		p_req.push = enq && to_prio && !tgt_full;
		n_req.push = enq && !to_prio && !tgt_full;
		// strict priority on the way out
		p_req.pop  = deq && !p_stat.empty;
		n_req.pop  = deq && p_stat.empty && !n_stat.empty;
	end

	always_comb begin
		if (kind == KIND_ENQ) begin
			status_d = tgt_full ? ST_REJECTED : ST_ENQUEUED;
			prio_d   = to_prio;
		end else begin
			status_d = (p_stat.empty && n_stat.empty) ? ST_EMPTY : ST_SERVED;
			prio_d   = !p_stat.empty;
		end
	end

	tcpq_lane u_prio_lane (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (p_req),
		.wr_entry (wr_entry),
		.stat     (p_stat),
		.rd_entry (p_rd)
	);

	tcpq_lane u_norm_lane (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (n_req),
		.wr_entry (wr_entry),
		.stat     (n_stat),
		.rd_entry (n_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= acc;
		end
	end

	// result payload, no reset needed
	always_ff @(posedge clk) begin
		if (acc) begin
			status_s1 <= status_d;
			prio_s1   <= prio_d;
		end
	end

	// served entry comes straight from the lane read register
	assign sel_entry = prio_s1 ? p_rd : n_rd;

	assign done          = valid_s1;
	assign status        = status_s1;
	// both-empty answer carries zero from_priority, tag and age fields
	assign from_priority = (status_s1 == ST_EMPTY) ? 1'b0 : prio_s1;
	assign served_tag    = (status_s1 == ST_SERVED) ? sel_entry[ENTRY_W-1:AGE_W] : '0;
	assign served_age    = (status_s1 == ST_SERVED) ? sel_entry[AGE_W-1:0] : '0;

	// one result for every accepted request, in the next cycle
	a_done_follows: assert property (@(posedge clk) disable iff (!arst_n)
		acc |=> done)
		else $error("no result after accepted request");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		!acc |=> !done)
		else $error("result without request");

	// normal queue served only while priority queue was empty
	a_strict_prio: assert property (@(posedge clk) disable iff (!arst_n)
		deq && !p_stat.empty |=> (status == ST_SERVED) && from_priority)
		else $error("priority head skipped");

	// dequeue with both queues empty reports zeros
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		deq && p_stat.empty && n_stat.empty |=>
			(status == ST_EMPTY) && (served_tag == '0) && (served_age == '0))
		else $error("empty dequeue fields not zero");

endmodule

FILE: tb/sv/tcpq_reply_checker.sv
// ----------------------------------------------------------------------------
// tcpq_reply_checker
// watches the request, result and threshold channels of the two-class
// priority queue, predicts every reply from its own copy of both lanes and
// compares it field by field with what the block returns
// ----------------------------------------------------------------------------
module tcpq_reply_checker
	import tcpq_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic             busy,
	input  logic             kind,
	input  logic [TAG_W-1:0] tag,
	input  logic [AGE_W-1:0] age,
	input  logic             done,
	input  logic [1:0]       status,
	input  logic             from_priority,
	input  logic [TAG_W-1:0] served_tag,
	input  logic [AGE_W-1:0] served_age,
	input  logic             cfg_valid,
	input  logic             cfg_ready,
	input  logic [AGE_W-1:0] cfg_data,
	output int               mismatch_count,
	output int               replies_pending
);

	localparam int LANE_NORMAL   = 0;
	localparam int LANE_PRIORITY = 1;

	typedef struct packed {
		status_t          status;
		logic             prio;
		logic [TAG_W-1:0] tag;
		logic [AGE_W-1:0] age;
	} queue_reply_t;

	// own copy of both lanes and the threshold
	logic [ENTRY_W-1:0] lane_slot [2][QUEUE_DEPTH];
	int                 lane_head [2];
	int                 lane_tail [2];
	logic               lane_empty [2];
	logic [AGE_W-1:0]   threshold;

	queue_reply_t replies_due [$];

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("%0t: %s mismatch, got %h want %h", $realtime, what, got, want);
		mismatch_count++;
	endtask

	function automatic queue_reply_t serve_request(input logic k,
			input logic [TAG_W-1:0] t, input logic [AGE_W-1:0] a);
		queue_reply_t r;
		int lane;
		r = '0;
		if (k == KIND_ENQ) begin
			lane = (a > threshold) ? LANE_PRIORITY : LANE_NORMAL;
			r.prio = (lane == LANE_PRIORITY);
			if (lane_empty[lane]) begin
				lane_head[lane] = 0;
				lane_tail[lane] = 0;
				lane_slot[lane][0] = {t, a};
				lane_empty[lane] = 1'b0;
				r.status = ST_ENQUEUED;
			end else if (lane_tail[lane] >= QUEUE_DEPTH - 1) begin
				// linear lane: no reuse of freed slots until it drains
				r.status = ST_REJECTED;
			end else begin
				lane_tail[lane]++;
				lane_slot[lane][lane_tail[lane]] = {t, a};
				r.status = ST_ENQUEUED;
			end
		end else if (!lane_empty[LANE_PRIORITY] || !lane_empty[LANE_NORMAL]) begin
			lane = lane_empty[LANE_PRIORITY] ? LANE_NORMAL : LANE_PRIORITY;
			r.prio = (lane == LANE_PRIORITY);
			r.status = ST_SERVED;
			{r.tag, r.age} = lane_slot[lane][lane_head[lane]];
			if (lane_head[lane] == lane_tail[lane]) begin
				lane_head[lane] = 0;
				lane_tail[lane] = 0;
				lane_empty[lane] = 1'b1;
			end else begin
				lane_head[lane]++;
			end
		end else begin
			r.status = ST_EMPTY;
		end
		return r;
	endfunction

	initial mismatch_count = 0;

	always @(posedge clk or negedge arst_n) begin : watch
		queue_reply_t want;
		if (!arst_n) begin
			for (int i = 0; i < 2; i++) begin
				lane_head[i] = 0;
				lane_tail[i] = 0;
				lane_empty[i] = 1'b1;
			end
			threshold = AGE_THRESHOLD_RESET;
			replies_due.delete();
			replies_pending <= 0;
		end else begin
			if (cfg_valid && cfg_ready)
				threshold = cfg_data;
			if (start && !busy)
				replies_due.push_back(serve_request(kind, tag, age));
			if (done) begin
				if (replies_due.size() == 0) begin
					report_mismatch("unexpected result", 32'(status), 32'd0);
				end else begin
					want = replies_due.pop_front();
					if (status !== want.status)
						report_mismatch("status", 32'(status), 32'(want.status));
					if (from_priority !== want.prio)
						report_mismatch("from_priority", 32'(from_priority),
							32'(want.prio));
					if (served_tag !== want.tag)
						report_mismatch("served_tag", 32'(served_tag), 32'(want.tag));
					if (served_age !== want.age)
						report_mismatch("served_age", 32'(served_age), 32'(want.age));
				end
			end
			replies_pending <= replies_due.size();
		end
	end

endmodule

FILE: tb/sv/tb_two_class_priority_queue.sv
// ----------------------------------------------------------------------------
// tb_two_class_priority_queue
// drives enqueue and dequeue words into the two-class priority queue through
// several threshold settings and sender idle patterns; a checker beside the
// block predicts and compares every reply, this top gives the verdict
// ----------------------------------------------------------------------------
module tb_two_class_priority_queue;

	import tcpq_pkg::*;

	logic             clk;
	logic             arst_n;
	logic             start;
	logic             busy;
	logic             kind;
	logic [TAG_W-1:0] tag;
	logic [AGE_W-1:0] age;
	logic             done;
	logic [1:0]       status;
	logic             from_priority;
	logic [TAG_W-1:0] served_tag;
	logic [AGE_W-1:0] served_age;
	logic             cfg_valid;
	logic             cfg_ready;
	logic [AGE_W-1:0] cfg_data;

	int mismatch_count;
	int replies_pending;

	// stimulus-side knowledge: chance of an idle cycle before each word, and
	// the threshold currently loaded (used only to aim ages near the boundary)
	int               idle_pct;
	logic [AGE_W-1:0] age_limit;

	two_class_priority_queue dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.kind          (kind),
		.tag           (tag),
		.age           (age),
		.done          (done),
		.status        (status),
		.from_priority (from_priority),
		.served_tag    (served_tag),
		.served_age    (served_age),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data)
	);

	tcpq_reply_checker checker_i (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.busy            (busy),
		.kind            (kind),
		.tag             (tag),
		.age             (age),
		.done            (done),
		.status          (status),
		.from_priority   (from_priority),
		.served_tag      (served_tag),
		.served_age      (served_age),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_data        (cfg_data),
		.mismatch_count  (mismatch_count),
		.replies_pending (replies_pending)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// hard stop well beyond the slowest legal run
	initial begin
		#4000000;
		$display("[two_class_priority_queue] ERROR");
		$finish;
	end

	// one request word; called at a falling edge, returns at a falling edge
	// after the word was taken. idle cycles in front carry random noise on
	// the payload so the block is seen ignoring it while start is low
	task automatic send_request(input logic k, input logic [TAG_W-1:0] t,
			input logic [AGE_W-1:0] a);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			kind  <= 1'($urandom_range(1));
			tag   <= TAG_W'($urandom_range(65535));
			age   <= AGE_W'($urandom_range(255));
			@(negedge clk);
		end
		start <= 1'b1;
		kind  <= k;
		tag   <= t;
		age   <= a;
		do @(posedge clk); while (busy);
		@(negedge clk);
	endtask

	// threshold write, only issued with no reply outstanding
	task automatic write_threshold(input logic [AGE_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
		cfg_data  <= AGE_W'($urandom_range(255));
		age_limit = value;
	endtask

	// wait at falling edges until every predicted reply has come back
	task automatic wait_replies(input int limit);
		int n;
		n = 0;
		while (replies_pending != 0 && n < limit) begin
			@(negedge clk);
			n++;
		end
	endtask

	// age picker: boundary values dominate, class_mode forces one lane
	// (1 = priority, 2 = normal) where the threshold leaves room for it
	function automatic logic [AGE_W-1:0] pick_age(input int class_mode);
		logic [AGE_W-1:0] a;
		if (class_mode == 1 && age_limit != 8'hff)
			a = AGE_W'($urandom_range(255, int'(age_limit) + 1));
		else if (class_mode == 2)
			a = AGE_W'($urandom_range(int'(age_limit), 0));
		else begin
			case ($urandom_range(5))
				0: a = 8'h00;
				1: a = 8'hff;
				2: a = age_limit;
				3: a = age_limit + 8'd1;
				default: a = AGE_W'($urandom_range(255));
			endcase
		end
		return a;
	endfunction

	function automatic logic [TAG_W-1:0] pick_tag();
		logic [TAG_W-1:0] t;
		case ($urandom_range(9))
			0: t = '0;
			1: t = '1;
			default: t = TAG_W'($urandom_range(65535));
		endcase
		return t;
	endfunction

	initial begin : stimulus
		int phase_idle [6];
		int phase_thr [6];
		int done_items;
		int seg_len;
		int enq_pct;
		int class_mode;
		logic k;

		phase_idle = '{0, 69, 37, 0, 69, 37};
		// reset threshold first, then both extremes, a midpoint, a random one, 65 again
		phase_thr = '{65, 0, 255, 128, -1, 65};

		arst_n    = 1'b0;
		start     = 1'b0;
		kind      = KIND_ENQ;
		tag       = '0;
		age       = '0;
		cfg_valid = 1'b0;
		cfg_data  = '0;
		idle_pct  = 0;
		age_limit = AGE_THRESHOLD_RESET;

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: empty dequeue with junk payload, boundary ages, strict
		// priority order, drain back to empty, reuse of a drained lane
		send_request(KIND_DEQ, 16'hffff, 8'hff);
		send_request(KIND_ENQ, 16'h0000, 8'h00);
		send_request(KIND_ENQ, 16'hffff, 8'hff);
		send_request(KIND_ENQ, 16'h1234, 8'd65);
		send_request(KIND_ENQ, 16'habcd, 8'd66);
		send_request(KIND_DEQ, 16'h5a5a, 8'h5a);
		send_request(KIND_DEQ, 16'h0000, 8'h00);
		send_request(KIND_DEQ, 16'ha5a5, 8'ha5);
		send_request(KIND_DEQ, 16'h0000, 8'h00);
		send_request(KIND_DEQ, 16'h0000, 8'h00);
		send_request(KIND_ENQ, 16'h5555, 8'd65);
		send_request(KIND_ENQ, 16'haaaa, 8'd200);
		send_request(KIND_DEQ, 16'h0000, 8'h00);
		send_request(KIND_ENQ, 16'h8001, 8'h80);
		send_request(KIND_DEQ, 16'h0000, 8'h00);
		send_request(KIND_DEQ, 16'h0000, 8'h00);
		send_request(KIND_DEQ, 16'h0000, 8'h00);
		start <= 1'b0;

		for (int p = 0; p < 6; p++) begin
			// config only between phases, with nothing in flight
			wait_replies(1000);
			repeat (3) @(negedge clk);
			if (p != 0)
				write_threshold(phase_thr[p] < 0 ? AGE_W'($urandom_range(1, 254))
				                                 : AGE_W'(phase_thr[p]));
			idle_pct = phase_idle[p];
			done_items = 0;
			while (done_items < 280) begin
				// segments pick at random between filling and draining pressure so
				// lanes reach their last slot and also empty out again
				seg_len = $urandom_range(10, 150);
				case ($urandom_range(3))
					0: enq_pct = 15;
					1: enq_pct = 50;
					2: enq_pct = 85;
					default: enq_pct = 100;
				endcase
				class_mode = $urandom_range(2);
				for (int i = 0; i < seg_len && done_items < 280; i++) begin
					k = ($urandom_range(99) < enq_pct) ? KIND_ENQ : KIND_DEQ;
					send_request(k, pick_tag(), pick_age(class_mode));
					done_items++;
				end
			end
			start <= 1'b0;
			@(negedge clk);
		end

		wait_replies(1000);
		repeat (5) @(negedge clk);
		if (replies_pending == 0 && mismatch_count == 0)
			$display("[two_class_priority_queue] OK");
		else
			$display("[two_class_priority_queue] ERROR");
		$finish;
	end

endmodule

FILE: sim.f
src/tcpq_pkg.sv
src/tcpq_lane.sv
src/two_class_priority_queue.sv
tb/sv/tcpq_reply_checker.sv
tb/sv/tb_two_class_priority_queue.sv
